// File: rtl/core/lfu_pkg.sv
// lfu_pkg: shared widths, codes and types for the LFU cache table.
// Used by lfu_scan_unit and lfu_cache_table; depends on nothing else.

package lfu_pkg;

   localparam int DEF_ENTRIES = 16;
   localparam int CAP_W       = 5;
   localparam int SLOT_W      = 5;
   localparam int MAX_SLOTS   = (1 << CAP_W) - 1;
   localparam int KEY_W       = 32;
   localparam int DATA_W      = 32;
   localparam int COUNT_W     = 32;
   localparam int STAMP_W     = 64;

   localparam logic [CAP_W-1:0]   CAP_RESET  = CAP_W'(16);
   localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
   localparam logic [COUNT_W-1:0] COUNT_ONE  = COUNT_W'(1);
   localparam logic [DATA_W-1:0]  MISS_VALUE = '1;
   localparam logic [DATA_W-1:0]  PUT_VALUE  = '0;

   typedef enum logic {
      OP_GET = 1'b0,
      OP_PUT = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [DATA_W-1:0]  value;
      logic [COUNT_W-1:0] count;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   typedef struct packed {
      logic                found;
      logic [SLOT_W-1:0]   found_idx;
      logic [DATA_W-1:0]   found_value;
      logic [COUNT_W-1:0]  found_count;
      logic                free_found;
      logic [SLOT_W-1:0]   free_idx;
      logic                best_found;
      logic [SLOT_W-1:0]   best_idx;
   } scan_result_type;

endpackage

// File: rtl/core/lfu_scan_unit.sv
// lfu_scan_unit: shared compare unit, one table entry per cycle while check_en is high.
// Tracks key match, first free slot and eviction victim; uses lfu_pkg.

module lfu_scan_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clear,
   input  logic                          check_en,
   input  logic [lfu_pkg::SLOT_W-1:0]    check_idx,
   input  logic                          check_valid,
   input  lfu_pkg::entry_type            check_entry,
   input  logic [lfu_pkg::KEY_W-1:0]     lookup_key,
   output lfu_pkg::scan_result_type      result
);

   logic                           found_ff, found_in;
   logic [lfu_pkg::SLOT_W-1:0]     found_idx_ff, found_idx_in;
   logic [lfu_pkg::DATA_W-1:0]     found_value_ff, found_value_in;
   logic [lfu_pkg::COUNT_W-1:0]    found_count_ff, found_count_in;
   logic                           free_found_ff, free_found_in;
   logic [lfu_pkg::SLOT_W-1:0]     free_idx_ff, free_idx_in;
   logic                           best_found_ff, best_found_in;
   logic [lfu_pkg::SLOT_W-1:0]     best_idx_ff, best_idx_in;
   logic [lfu_pkg::COUNT_W-1:0]    best_count_ff, best_count_in;
   logic [lfu_pkg::STAMP_W-1:0]    best_stamp_ff, best_stamp_in;
   logic                           better;

   // lowest count, then oldest stamp; strict so the lowest slot wins ties
   assign better = !best_found_ff
                   || (check_entry.count < best_count_ff)
                   || ((check_entry.count == best_count_ff)
                       && (check_entry.stamp < best_stamp_ff));

   always_comb begin
      found_in       = found_ff;
      found_idx_in   = found_idx_ff;
      found_value_in = found_value_ff;
      found_count_in = found_count_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      best_found_in  = best_found_ff;
      best_idx_in    = best_idx_ff;
      best_count_in  = best_count_ff;
      best_stamp_in  = best_stamp_ff;
      if (clear) begin
         found_in      = 1'b0;
         free_found_in = 1'b0;
         best_found_in = 1'b0;
      end else if (check_en) begin
         if (check_valid) begin
            if (!found_ff && (check_entry.key == lookup_key)) begin
               found_in       = 1'b1;
               found_idx_in   = check_idx;
               found_value_in = check_entry.value;
               found_count_in = check_entry.count;
            end
            if (better) begin
               best_found_in = 1'b1;
               best_idx_in   = check_idx;
               best_count_in = check_entry.count;
               best_stamp_in = check_entry.stamp;
            end
         end else if (!free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = check_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         best_found_ff <= 1'b0;
      end else begin
         found_ff      <= found_in;
         free_found_ff <= free_found_in;
         best_found_ff <= best_found_in;
      end
      found_idx_ff   <= found_idx_in;
      found_value_ff <= found_value_in;
      found_count_ff <= found_count_in;
      free_idx_ff    <= free_idx_in;
      best_idx_ff    <= best_idx_in;
      best_count_ff  <= best_count_in;
      best_stamp_ff  <= best_stamp_in;
   end

   always_comb begin
      result.found       = found_ff;
      result.found_idx   = found_idx_ff;
      result.found_value = found_value_ff;
      result.found_count = found_count_ff;
      result.free_found  = free_found_ff;
      result.free_idx    = free_idx_ff;
      result.best_found  = best_found_ff;
      result.best_idx    = best_idx_ff;
   end

endmodule

// File: rtl/core/lfu_cache_table.sv
// lfu_cache_table: top level of the LFU cache with least-recently-counted
// tie-break. Uses lfu_pkg and lfu_scan_unit.
//
// Request channel (req_*): opcode get or put, key and write value. A transfer
// happens when req_valid is high and req_stall low. req_stall is high from the
// transfer until the result has been placed in the output register.
// Response channel (rsp_*): hit flag and read value, one per request, held in
// an output register until the receiver takes it (rsp_valid high, rsp_stall
// low). A new request is taken while that result still waits.
// Each request reads all SLOTS entries in order, where SLOTS is min(ENTRIES,
// 31), from the entry memory into the shared scan unit, then passes the drain,
// update and response load states. The next request is taken in the cycle
// after the response load, so a new request is not taken until the previous
// one has loaded its response.
// If the receiver stalls with a result pending, the following request finishes
// its scan and waits before its own response load.
// csr_wr_en writes the capacity register (reset 16); write only while idle.
// Reset (synchronous) clears all valid bits, the fill count, the request clock
// and the output valid flag; no clearing pass is needed.

module lfu_cache_table #(
   parameter int ENTRIES = lfu_pkg::DEF_ENTRIES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_opcode,
   input  logic signed [lfu_pkg::KEY_W-1:0]  req_lookup_key,
   input  logic signed [lfu_pkg::DATA_W-1:0] req_write_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_hit,
   output logic signed [lfu_pkg::DATA_W-1:0] rsp_read_value,
   input  logic                             csr_wr_en,
   input  logic [lfu_pkg::CAP_W-1:0]        csr_wr_data
);

   localparam int SLOTS = (ENTRIES < lfu_pkg::MAX_SLOTS) ? ENTRIES : lfu_pkg::MAX_SLOTS;
   localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IW-1:0]            LAST_IDX = IW'(SLOTS - 1);
   localparam logic [lfu_pkg::CAP_W-1:0] CAP_TOP = lfu_pkg::CAP_W'(SLOTS);

   lfu_pkg::state_type            state_ff, state_in;
   logic [IW-1:0]                 issue_idx_ff, issue_idx_in;
   logic                          chk_vld_ff, chk_vld_in;
   logic [lfu_pkg::SLOT_W-1:0]    chk_idx_ff, chk_idx_in;
   lfu_pkg::op_type               op_ff, op_in;
   logic [lfu_pkg::KEY_W-1:0]     key_ff, key_in;
   logic [lfu_pkg::DATA_W-1:0]    val_ff, val_in;
   logic [lfu_pkg::STAMP_W-1:0]   clock_ff, clock_in;
   logic [lfu_pkg::CAP_W-1:0]     fill_ff, fill_in;
   logic [lfu_pkg::CAP_W-1:0]     capacity_ff, capacity_in;
   logic [SLOTS-1:0]              valid_ff, valid_in;
   logic                          hit_ff, hit_in;
   logic [lfu_pkg::DATA_W-1:0]    rd_ff, rd_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_hit_ff, rsp_hit_in;
   logic [lfu_pkg::DATA_W-1:0]    rsp_value_ff, rsp_value_in;

   lfu_pkg::entry_type            mem [SLOTS];
   lfu_pkg::entry_type            rd_data_ff;
   logic [IW-1:0]                 rd_addr;
   logic                          wr_en;
   logic [IW-1:0]                 wr_addr;
   lfu_pkg::entry_type            wr_data;

   logic                          scan_clear;
   lfu_pkg::scan_result_type      scan;
   logic [lfu_pkg::CAP_W-1:0]     cap_eff;
   logic [lfu_pkg::COUNT_W-1:0]   count_bump;

   assign cap_eff    = (capacity_ff > CAP_TOP) ? CAP_TOP : capacity_ff;
   assign count_bump = (scan.found_count == lfu_pkg::COUNT_MAX) ? scan.found_count
                       : scan.found_count + lfu_pkg::COUNT_ONE;

   lfu_scan_unit u_scan (
      .clock       (clock),
      .reset       (reset),
      .clear       (scan_clear),
      .check_en    (chk_vld_ff),
      .check_idx   (chk_idx_ff),
      .check_valid (valid_ff[chk_idx_ff[IW-1:0]]),
      .check_entry (rd_data_ff),
      .lookup_key  (key_ff),
      .result      (scan)
   );

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in     = state_ff;
      issue_idx_in = issue_idx_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = chk_idx_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      clock_in     = clock_ff;
      fill_in      = fill_ff;
      capacity_in  = csr_wr_en ? csr_wr_data : capacity_ff;
      valid_in     = valid_ff;
      hit_in       = hit_ff;
      rd_in        = rd_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_hit_in   = rsp_hit_ff;
      rsp_value_in = rsp_value_ff;
      rd_addr      = issue_idx_ff;
      wr_en        = 1'b0;
      wr_addr      = scan.found_idx[IW-1:0];
      wr_data      = '{key: key_ff, value: val_ff, count: count_bump, stamp: clock_ff};
      scan_clear   = 1'b0;
      req_stall    = 1'b1;

      unique case (state_ff)
         lfu_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               op_in        = lfu_pkg::op_type'(req_opcode);
               key_in       = req_lookup_key;
               val_in       = req_write_value;
               clock_in     = clock_ff + lfu_pkg::STAMP_W'(1);
               issue_idx_in = '0;
               scan_clear   = 1'b1;
               state_in     = lfu_pkg::ST_SCAN;
            end
         end
         lfu_pkg::ST_SCAN: begin
            chk_vld_in = 1'b1;
            chk_idx_in = lfu_pkg::SLOT_W'(issue_idx_ff);
            if (issue_idx_ff == LAST_IDX) begin
               state_in = lfu_pkg::ST_DRAIN;
            end else begin
               issue_idx_in = issue_idx_ff + IW'(1);
            end
         end
         lfu_pkg::ST_DRAIN: begin
            state_in = lfu_pkg::ST_UPDATE;
         end
         lfu_pkg::ST_UPDATE: begin
            hit_in   = scan.found;
            state_in = lfu_pkg::ST_RESP;
            if (op_ff == lfu_pkg::OP_GET) begin
               rd_in = scan.found ? scan.found_value : lfu_pkg::MISS_VALUE;
               if (scan.found) begin
                  wr_en         = 1'b1;
                  wr_data.value = scan.found_value;
               end
            end else begin
               rd_in = lfu_pkg::PUT_VALUE;
               if (cap_eff != '0 || capacity_ff != '0) begin
                  if (scan.found) begin
                     wr_en = 1'b1;
                  end else begin
                     wr_data.count = lfu_pkg::COUNT_ONE;
                     if ((fill_ff < cap_eff) && scan.free_found) begin
                        wr_en   = 1'b1;
                        wr_addr = scan.free_idx[IW-1:0];
                        fill_in = fill_ff + lfu_pkg::CAP_W'(1);
                        valid_in[scan.free_idx[IW-1:0]] = 1'b1;
                     end else if (scan.best_found) begin
                        // evicted slot is reused at once, so the fill is unchanged unless it was zero
                        wr_en   = 1'b1;
                        wr_addr = scan.best_idx[IW-1:0];
                        fill_in = (fill_ff == '0) ? lfu_pkg::CAP_W'(1) : fill_ff;
                     end
                  end
               end
            end
         end
         lfu_pkg::ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_ff;
               rsp_value_in = rd_ff;
               state_in     = lfu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lfu_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lfu_pkg::ST_IDLE;
         chk_vld_ff   <= 1'b0;
         clock_ff     <= '0;
         fill_ff      <= '0;
         capacity_ff  <= lfu_pkg::CAP_RESET;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_vld_ff   <= chk_vld_in;
         clock_ff     <= clock_in;
         fill_ff      <= fill_in;
         capacity_ff  <= capacity_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      issue_idx_ff <= issue_idx_in;
      chk_idx_ff   <= chk_idx_in;
      op_ff        <= op_in;
      key_ff       <= key_in;
      val_ff       <= val_in;
      hit_ff       <= hit_in;
      rd_ff        <= rd_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_value_ff;

endmodule

// File: verif/lfu_cache_table_test.sv
`timescale 1ns / 100ps
// lfu_cache_table_test: self-checking bench for lfu_cache_table, with an LFU
// predictor (least-recently-counted tie-break) and in-order result checks.
// Depends on lfu_pkg and the lfu_cache_table RTL only.

module lfu_cache_table_test;

   localparam int SLOTS   = lfu_pkg::DEF_ENTRIES;
   localparam int LATENCY = SLOTS + 4;

   typedef struct packed {
      logic                       hit;
      logic [lfu_pkg::DATA_W-1:0] read_value;
   } lookup_result_type;

   logic                              clock           = 1'b0;
   logic                              reset           = 1'b1;
   logic                              req_valid       = 1'b0;
   logic                              req_stall;
   logic                              req_opcode      = lfu_pkg::OP_GET;
   logic signed [lfu_pkg::KEY_W-1:0]  req_lookup_key  = '0;
   logic signed [lfu_pkg::DATA_W-1:0] req_write_value = '0;
   logic                              rsp_valid;
   logic                              rsp_stall       = 1'b0;
   logic                              rsp_hit;
   logic signed [lfu_pkg::DATA_W-1:0] rsp_read_value;
   logic                              csr_wr_en       = 1'b0;
   logic [lfu_pkg::CAP_W-1:0]         csr_wr_data     = '0;

   lfu_cache_table u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_lookup_key  (req_lookup_key),
      .req_write_value (req_write_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_read_value  (rsp_read_value),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   // predictor state
   logic [lfu_pkg::CAP_W-1:0]   cap_setting = lfu_pkg::CAP_RESET;
   bit   [SLOTS-1:0]            slot_used   = '0;
   logic [lfu_pkg::KEY_W-1:0]   slot_key   [SLOTS];
   logic [lfu_pkg::DATA_W-1:0]  slot_value [SLOTS];
   logic [lfu_pkg::COUNT_W-1:0] slot_count [SLOTS];
   logic [lfu_pkg::STAMP_W-1:0] slot_stamp [SLOTS];
   logic [lfu_pkg::STAMP_W-1:0] request_clock = '0;
   int unsigned                 fill_level    = 0;

   lookup_result_type pending_results[$];

   int unsigned transfers  = 0;
   int unsigned hits       = 0;
   int unsigned evictions  = 0;
   int unsigned cfg_writes = 0;
   int unsigned errors     = 0;
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("lfu_cache_table_test failed");
      $finish;
   end

   function automatic int find_key_slot(logic [lfu_pkg::KEY_W-1:0] key);
      for (int i = 0; i < SLOTS; i++)
         if (slot_used[i] && slot_key[i] == key)
            return i;
      return -1;
   endfunction

   function automatic void count_use(int s);
      if (slot_count[s] != lfu_pkg::COUNT_MAX)
         slot_count[s]++;
      slot_stamp[s] = request_clock;
   endfunction

   // free slot below capacity, else evict lowest count, oldest stamp, lowest slot
   function automatic int claim_slot();
      int unsigned limit;
      int          victim;
      limit  = (cap_setting > SLOTS) ? SLOTS : cap_setting;
      victim = -1;
      if (fill_level < limit)
         for (int i = 0; i < SLOTS; i++)
            if (!slot_used[i])
               return i;
      for (int i = 0; i < SLOTS; i++)
         if (slot_used[i] && (victim < 0 || slot_count[i] < slot_count[victim] ||
             (slot_count[i] == slot_count[victim] &&
              slot_stamp[i] < slot_stamp[victim])))
            victim = i;
      if (victim >= 0) begin
         slot_used[victim] = 1'b0;
         if (fill_level > 0)
            fill_level--;
         evictions++;
      end
      return victim;
   endfunction

   function automatic lookup_result_type lfu_access(lfu_pkg::op_type op,
                                                    logic [lfu_pkg::KEY_W-1:0] key,
                                                    logic [lfu_pkg::DATA_W-1:0] wdata);
      int                s;
      lookup_result_type res;
      s              = find_key_slot(key);
      res.hit        = (s >= 0);
      res.read_value = lfu_pkg::PUT_VALUE;
      request_clock++;
      if (res.hit)
         hits++;
      if (op == lfu_pkg::OP_GET) begin
         if (s >= 0) begin
            count_use(s);
            res.read_value = slot_value[s];
         end else begin
            res.read_value = lfu_pkg::MISS_VALUE;
         end
      end else if (cap_setting != 0) begin
         if (s >= 0) begin
            count_use(s);
            slot_value[s] = wdata;
         end else begin
            s = claim_slot();
            if (s >= 0) begin
               slot_used[s]  = 1'b1;
               slot_key[s]   = key;
               slot_value[s] = wdata;
               slot_count[s] = lfu_pkg::COUNT_ONE;
               slot_stamp[s] = request_clock;
               fill_level++;
            end
         end
      end
      return res;
   endfunction

   // valid is left high after a transfer; the next call may lower it for a random gap
   task automatic send_request(lfu_pkg::op_type op, logic [lfu_pkg::KEY_W-1:0] key,
                               logic [lfu_pkg::DATA_W-1:0] wdata);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_lookup_key  <= key;
      req_write_value <= wdata;
      do @(posedge clock); while (req_stall);
      pending_results.insert(pending_results.size(), lfu_access(op, key, wdata));
      transfers++;
   endtask

   task automatic end_requests();
      req_valid <= 1'b0;
   endtask

   task automatic set_capacity(logic [lfu_pkg::CAP_W-1:0] value);
      end_requests();
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      cap_setting = value;
      cfg_writes++;
      csr_wr_en <= 1'b0;
   endtask

   always @(posedge clock) begin : check_results
      lookup_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: result with none expected, hit %0b read_value %h",
                     $time, rsp_hit, rsp_read_value);
         end else begin
            want = pending_results.pop_front();
            if (rsp_hit !== want.hit) begin
               errors++;
               $display("%0t: hit expected %0b actual %0b", $time, want.hit, rsp_hit);
            end
            if (rsp_read_value !== want.read_value) begin
               errors++;
               $display("%0t: read_value expected %h actual %h",
                        $time, want.read_value, rsp_read_value);
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // empty table, extreme keys and values, update of a present key
   task automatic test_basic_access();
      send_request(lfu_pkg::OP_GET, 32'h0000_0000, 32'h1234_5678);
      send_request(lfu_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(lfu_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(lfu_pkg::OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(lfu_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000);
      send_request(lfu_pkg::OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_request(lfu_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
      send_request(lfu_pkg::OP_PUT, 32'h0000_0000, 32'h0000_0000);
      send_request(lfu_pkg::OP_GET, 32'h0000_0000, 32'h5555_5555);
      send_request(lfu_pkg::OP_GET, 32'hFFFF_FFFF, 32'hAAAA_AAAA);
   endtask

   // capacity below the fill; ties on count go to the oldest stamp
   task automatic test_eviction_order();
      set_capacity(lfu_pkg::CAP_W'(2));
      send_request(lfu_pkg::OP_PUT, 32'd100, 32'd1);
      send_request(lfu_pkg::OP_PUT, 32'd101, 32'd2);
      send_request(lfu_pkg::OP_GET, 32'd100, 32'd0);
      send_request(lfu_pkg::OP_PUT, 32'd102, 32'd3);
      send_request(lfu_pkg::OP_GET, 32'd101, 32'd0);
      send_request(lfu_pkg::OP_GET, 32'h7FFF_FFFF, 32'd0);
   endtask

   // nothing stored: puts of absent keys leave no entry, so the later get misses
   task automatic test_zero_capacity();
      set_capacity(lfu_pkg::CAP_W'(0));
      send_request(lfu_pkg::OP_PUT, 32'hDEAD_BEEF, 32'd7);
      send_request(lfu_pkg::OP_PUT, 32'd100, 32'hCAFE_F00D);
      send_request(lfu_pkg::OP_GET, 32'd100, 32'd0);
   endtask

   // hot-key traffic over a small pool so hits and evictions both happen
   task automatic run_traffic(logic [lfu_pkg::CAP_W-1:0] cap, int unsigned n_items,
                              int unsigned send_pct, int unsigned recv_pct,
                              int unsigned pool_size);
      logic [lfu_pkg::KEY_W-1:0] key_pool[$];
      logic [lfu_pkg::KEY_W-1:0] key;
      lfu_pkg::op_type           op;
      set_capacity(cap);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      for (int i = 0; i < pool_size; i++)
         key_pool.insert(key_pool.size(), $urandom);
      for (int n = 0; n < n_items; n++) begin
         if ($urandom_range(9) == 0)
            key = $urandom;
         else if ($urandom_range(1) == 0)
            key = key_pool[$urandom_range(pool_size / 4)];
         else
            key = key_pool[$urandom_range(pool_size - 1)];
         op = ($urandom_range(99) < 45) ? lfu_pkg::OP_PUT : lfu_pkg::OP_GET;
         send_request(op, key, $urandom);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_basic_access();
      test_eviction_order();
      test_zero_capacity();

      run_traffic(lfu_pkg::CAP_W'(16), 210, 0, 0, 24);
      run_traffic(lfu_pkg::CAP_W'(1), 210, 85, 0, 4);
      run_traffic(lfu_pkg::CAP_W'(5), 210, 0, 85, 9);
      run_traffic(lfu_pkg::CAP_W'(31), 210, 10, 10, 22);
      run_traffic(lfu_pkg::CAP_W'(0), 210, 0, 0, 16);
      run_traffic(lfu_pkg::CAP_W'(3), 210, 85, 0, 8);
      run_traffic(lfu_pkg::CAP_W'(17), 210, 0, 85, 20);
      run_traffic(lfu_pkg::CAP_W'($urandom_range(31)), 210, 10, 10, 12);

      end_requests();
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);

      $display("Covered %0d request transfers: %0d hits, %0d evictions, %0d capacity writes,",
               transfers, hits, evictions, cfg_writes);
      $display("capacities 0 to 31 under free-running, sender-idle and receiver-stall traffic.");
      if (errors == 0)
         $display("lfu_cache_table_test passed");
      else
         $display("lfu_cache_table_test failed");
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/lfu_pkg.sv
rtl/core/lfu_scan_unit.sv
rtl/core/lfu_cache_table.sv
verif/lfu_cache_table_test.sv
